@@ rtl/tlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants of the three-level priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

  localparam logic       OP_ENQ   = 1'b0;
  localparam logic       OP_DEQ   = 1'b1;
  localparam logic [1:0] PRIO_LOW = 2'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    enq;
    logic    deq;
    logic    load_out;
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/tlpq_datapath.sv @@
// ----------------------------------------------------------------------------
// tlpq_datapath
// Row of storage cells kept sorted by priority, plus the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_datapath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tlpq_pkg::cmd_t       cmd,
  output tlpq_pkg::sts_t            sts,
  input  wire logic [31:0]          new_value,
  input  wire logic [1:0]           new_priority,
  output logic [31:0]               front_value,
  output logic [31:0]               rear_value,
  output logic [4:0]                entry_count,
  output logic                      is_empty,
  output logic [1:0]                status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [DATA_WIDTH-1:0] val_r [CAPACITY];
  logic [1:0]            pri_r [CAPACITY];
  logic [CW-1:0]         count_r;

  logic [DATA_WIDTH-1:0] val_nxt [CAPACITY];
  logic [1:0]            pri_nxt [CAPACITY];
  logic [CAPACITY-1:0]   ge;

  logic [DATA_WIDTH+31:0] in_ext;
  logic [DATA_WIDTH-1:0]  in_val;
  logic [1:0]             in_pri;

  assign in_ext = {{DATA_WIDTH{1'b0}}, new_value};
  assign in_val = in_ext[DATA_WIDTH-1:0];
  // priority zero counts as low
  assign in_pri = (new_priority < tlpq_pkg::PRIO_LOW) ? tlpq_pkg::PRIO_LOW : new_priority;

  assign sts.full  = (count_r == CW'(CAPACITY));
  assign sts.empty = (count_r == '0);

  genvar k;
  generate
    for (k = 0; k < CAPACITY; k++) begin : g_cell
      logic occupied;
      logic prev_ge;
      assign occupied = (CW'(k) < count_r);
      assign ge[k]    = occupied && (pri_r[k] >= in_pri);
      if (k == 0) begin : g_first
        assign prev_ge = 1'b1;
      end else begin : g_rest
        assign prev_ge = ge[k-1];
      end

      always_comb begin
        val_nxt[k] = val_r[k];
        pri_nxt[k] = pri_r[k];
        if (cmd.enq) begin
          if (!ge[k]) begin
            // insertion point takes the new entry, cells behind it shift back
            if (prev_ge) begin
              val_nxt[k] = in_val;
              pri_nxt[k] = in_pri;
            end else begin
              val_nxt[k] = val_r[(k > 0) ? k - 1 : 0];
              pri_nxt[k] = pri_r[(k > 0) ? k - 1 : 0];
            end
          end
        end else if (cmd.deq) begin
          if (k < CAPACITY - 1) begin
            val_nxt[k] = val_r[(k < CAPACITY - 1) ? k + 1 : k];
            pri_nxt[k] = pri_r[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end

      always_ff @(posedge clk) begin
        val_r[k] <= val_nxt[k];
        pri_r[k] <= pri_nxt[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.enq) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.deq) begin
      count_r <= count_r - CW'(1);
    end
  end

  // result registers, loaded from the updated row
  logic [CW-1:0]          last;
  logic [IW-1:0]          rear_idx;
  logic [DATA_WIDTH+31:0] front_ext;
  logic [DATA_WIDTH+31:0] rear_ext;
  logic [CW+4:0]          cnt_ext;

  logic [31:0] front_r;
  logic [31:0] rear_r;
  logic [4:0]  count_out_r;
  logic        empty_r;
  logic [1:0]  status_r;

  assign last      = count_r - CW'(1);
  assign rear_idx  = last[IW-1:0];
  assign front_ext = {32'b0, val_r[0]};
  assign rear_ext  = {32'b0, val_r[rear_idx]};
  assign cnt_ext   = {5'b0, count_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      front_r     <= sts.empty ? 32'b0 : front_ext[31:0];
      rear_r      <= sts.empty ? 32'b0 : rear_ext[31:0];
      count_out_r <= cnt_ext[4:0];
      empty_r     <= sts.empty;
      status_r    <= cmd.status;
    end
  end

  assign front_value = front_r;
  assign rear_value  = rear_r;
  assign entry_count = count_out_r;
  assign is_empty    = empty_r;
  assign status      = status_r;

endmodule

`default_nettype wire

@@ rtl/tlpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Sequencer: takes one operation, updates the row, loads and sends the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_opcode,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire tlpq_pkg::sts_t  sts,
  output tlpq_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  tlpq_pkg::status_t status_r, status_nxt;
  logic              accept;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SEND);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    cmd.enq      = 1'b0;
    cmd.deq      = 1'b0;
    cmd.load_out = 1'b0;
    cmd.status   = status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = tlpq_pkg::ST_OK;
          if (in_opcode == tlpq_pkg::OP_DEQ) begin
            if (sts.empty) begin
              status_nxt = tlpq_pkg::ST_UNDERFLOW;
            end else begin
              cmd.deq = 1'b1;
            end
          end else begin
            if (sts.full) begin
              status_nxt = tlpq_pkg::ST_FULL;
            end else begin
              cmd.enq = 1'b1;
            end
          end
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_out = 1'b1;
        state_nxt    = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= tlpq_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/three_level_priority_queue.sv @@
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Bounded stable priority queue with three levels and a result per operation.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one operation per beat, either an
// enqueue of in_item_value at in_item_priority (1 low .. 3 high, 0 taken as
// low) or a dequeue of the front entry.
// Result channel: out_valid/out_stall carry one beat per operation with the
// front and rear values, entry count, empty flag and status (ok, underflow,
// full). Front and rear read zero when the queue is empty.
// Timing: an operation is accepted in the idle state and the row of cells
// compares and shifts in place at that edge; the result registers load in
// the load state on the next cycle and out_valid rises in the send state.
// One operation is in flight at a time: the controller steps through accept,
// load and send before it takes the next operation.
// A stalled result holds until taken; in_stall stays high meanwhile.
// Reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_priority_queue #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_item_value,
  input  wire logic [1:0]  in_item_priority,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_front_value,
  output logic [31:0]      out_rear_value,
  output logic [4:0]       out_entry_count,
  output logic             out_is_empty,
  output logic [1:0]       out_status
);

  tlpq_pkg::cmd_t cmd;
  tlpq_pkg::sts_t sts;

  tlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlpq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .new_value    (in_item_value),
    .new_priority (in_item_priority),
    .front_value  (out_front_value),
    .rear_value   (out_rear_value),
    .entry_count  (out_entry_count),
    .is_empty     (out_is_empty),
    .status       (out_status)
  );

endmodule

`default_nettype wire

@@ verif/three_level_priority_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_queue_tb
// Drives enqueue and dequeue beats with random gaps against random result
// stalls. A directed table opens the run: underflow, priority extremes,
// out-of-range priority and a fill up to a dropped enqueue. Biased random
// phases follow, pushing the queue between empty and full. Every result beat
// is checked field by field against a sorted-row predictor or a typed row view.
// ----------------------------------------------------------------------------

module three_level_priority_queue_tb;

  localparam int         QUEUE_DEPTH  = 16;
  localparam int         RANDOM_ITEMS = 1850;
  localparam int         DIR_ROWS     = 21;
  localparam logic [1:0] PRIO_NONE    = 2'd0;
  localparam logic [1:0] PRIO_MED     = 2'd2;
  localparam logic [1:0] PRIO_HIGH    = 2'd3;

  typedef struct packed {
    logic [31:0]       front;
    logic [31:0]       rear;
    logic [4:0]        count;
    logic              empty;
    tlpq_pkg::status_t status;
  } view_t;

  typedef struct packed {
    logic        op;
    logic [31:0] val;
    logic [1:0]  prio;
    logic        typed;
    view_t       view;
  } row_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_opcode        = tlpq_pkg::OP_ENQ;
  logic [31:0] in_item_value    = '0;
  logic [1:0]  in_item_priority = tlpq_pkg::PRIO_LOW;
  logic        out_stall        = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_front_value;
  logic [31:0] out_rear_value;
  logic [4:0]  out_entry_count;
  logic        out_is_empty;
  logic [1:0]  out_status;

  // predictor state: slot 0 is the front
  logic [31:0] slot_val [QUEUE_DEPTH];
  logic [1:0]  slot_prio[QUEUE_DEPTH];
  int          slot_used = 0;

  view_t pending_views[$];
  int    err_count = 0;

  row_t dir_rows[DIR_ROWS] = '{
    '{tlpq_pkg::OP_DEQ, 32'hFFFF_FFFF, PRIO_HIGH, 1'b1,
      '{32'h0, 32'h0, 5'd0, 1'b1, tlpq_pkg::ST_UNDERFLOW}},
    '{tlpq_pkg::OP_ENQ, 32'h0000_0000, tlpq_pkg::PRIO_LOW, 1'b1,
      '{32'h0, 32'h0, 5'd1, 1'b0, tlpq_pkg::ST_OK}},
    '{tlpq_pkg::OP_ENQ, 32'hFFFF_FFFF, PRIO_HIGH, 1'b1,
      '{32'hFFFF_FFFF, 32'h0, 5'd2, 1'b0, tlpq_pkg::ST_OK}},
    '{tlpq_pkg::OP_ENQ, 32'h1234_5678, PRIO_NONE, 1'b1,
      '{32'hFFFF_FFFF, 32'h1234_5678, 5'd3, 1'b0, tlpq_pkg::ST_OK}},
    '{tlpq_pkg::OP_ENQ, 32'hA5A5_A5A5, PRIO_MED,  1'b0, '0},
    '{tlpq_pkg::OP_DEQ, 32'h0000_0000, PRIO_NONE, 1'b0, '0},
    // fill to capacity with mixed levels
    '{tlpq_pkg::OP_ENQ, 32'h10, PRIO_MED,  1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h11, PRIO_HIGH, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h12, tlpq_pkg::PRIO_LOW, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h13, PRIO_MED,  1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h14, PRIO_HIGH, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h15, tlpq_pkg::PRIO_LOW, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h16, PRIO_MED,  1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h17, PRIO_HIGH, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h18, tlpq_pkg::PRIO_LOW, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h19, PRIO_MED,  1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h1A, PRIO_HIGH, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h1B, tlpq_pkg::PRIO_LOW, 1'b0, '0},
    '{tlpq_pkg::OP_ENQ, 32'h1C, tlpq_pkg::PRIO_LOW, 1'b0, '0},
    // queue full: dropped
    '{tlpq_pkg::OP_ENQ, 32'hDEAD_BEEF, PRIO_HIGH, 1'b1,
      '{32'h11, 32'h1C, 5'd16, 1'b0, tlpq_pkg::ST_FULL}},
    '{tlpq_pkg::OP_DEQ, 32'h5A5A_5A5A, tlpq_pkg::PRIO_LOW, 1'b0, '0}
  };

  three_level_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("three_level_priority_queue_tb NOT OK");
    $finish;
  end

  // applies one operation to the sorted row and returns what the block shows
  function automatic view_t apply_queue_op(input logic op, input logic [31:0] val,
                                           input logic [1:0] prio);
    view_t       v;
    logic [1:0]  p;
    int          pos;
    v.status = tlpq_pkg::ST_OK;
    p = (prio < tlpq_pkg::PRIO_LOW) ? tlpq_pkg::PRIO_LOW : prio;
    if (op == tlpq_pkg::OP_ENQ) begin
      if (slot_used >= QUEUE_DEPTH) begin
        v.status = tlpq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < slot_used && slot_prio[pos] >= p) pos++;
        for (int k = slot_used; k > pos; k--) begin
          slot_val[k]  = slot_val[k-1];
          slot_prio[k] = slot_prio[k-1];
        end
        slot_val[pos]  = val;
        slot_prio[pos] = p;
        slot_used++;
      end
    end else begin
      if (slot_used == 0) begin
        v.status = tlpq_pkg::ST_UNDERFLOW;
      end else begin
        for (int k = 1; k < slot_used; k++) begin
          slot_val[k-1]  = slot_val[k];
          slot_prio[k-1] = slot_prio[k];
        end
        slot_used--;
      end
    end
    v.front = (slot_used == 0) ? 32'h0 : slot_val[0];
    v.rear  = (slot_used == 0) ? 32'h0 : slot_val[slot_used-1];
    v.count = 5'(slot_used);
    v.empty = (slot_used == 0);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one input beat; called at a rising edge, returns at the accepting edge
  task automatic send_op(input logic op, input logic [31:0] val, input logic [1:0] prio,
                         input int gap, input logic typed, input view_t typed_view);
    view_t v;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_item_value    <= val;
    in_item_priority <= prio;
    do @(posedge clk); while (in_stall);
    v = apply_queue_op(op, val, prio);
    pending_views.push_back(typed ? typed_view : v);
  endtask

  // result side back-pressure
  initial begin
    int sel;
    int hold;
    logic level;
    forever begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        hold  = $urandom_range(20, 200);
        level = 1'b0;
      end else if (sel < 8) begin
        hold  = $urandom_range(1, 3);
        level = 1'b1;
      end else begin
        hold  = $urandom_range(10, 30);
        level = 1'b1;
      end
      @(posedge clk) out_stall <= level;
      repeat (hold - 1) @(posedge clk);
      @(posedge clk) out_stall <= 1'b0;
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result beat", out_front_value, 32'h0);
      end else begin
        want = pending_views.pop_front();
        if (out_front_value !== want.front)
          report_mismatch("front_value", out_front_value, want.front);
        if (out_rear_value !== want.rear)
          report_mismatch("rear_value", out_rear_value, want.rear);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", 32'(out_entry_count), 32'(want.count));
        if (out_is_empty !== want.empty)
          report_mismatch("is_empty", 32'(out_is_empty), 32'(want.empty));
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
      end
    end
  end

  initial begin
    int          sent;
    int          plen;
    int          enq_pct;
    bit          quiet;
    logic        op;
    logic [31:0] val;
    logic [1:0]  prio;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_op(dir_rows[i].op, dir_rows[i].val, dir_rows[i].prio, pick_gap(1'b0),
              dir_rows[i].typed, dir_rows[i].view);
    end

    // phases lean toward enqueue or dequeue so the row swings between empty and full
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      plen  = $urandom_range(40, 160);
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0:       enq_pct = 15;
        1:       enq_pct = 50;
        default: enq_pct = 85;
      endcase
      for (int i = 0; i < plen && sent < RANDOM_ITEMS; i++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? tlpq_pkg::OP_ENQ : tlpq_pkg::OP_DEQ;
        case ($urandom_range(0, 15))
          0:       val = 32'h0;
          1:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        prio = ($urandom_range(0, 9) == 0) ? PRIO_NONE : 2'($urandom_range(1, 3));
        send_op(op, val, prio, pick_gap(quiet), 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("three_level_priority_queue_tb OK");
    end else begin
      $display("three_level_priority_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
